// ===== rtl/rgb_gaussian_then_median_filter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the RGB Gaussian-then-median filter unit
// Shared forms for clocked checks with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef RGB_GAUSSIAN_THEN_MEDIAN_FILTER_UNIT_MACROS_SVH
`define RGB_GAUSSIAN_THEN_MEDIAN_FILTER_UNIT_MACROS_SVH

// Same-cycle implication
`define RGBGM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RGBGM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgbgm_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbgm_pkg
// Types and constants shared by the Gaussian-then-median filter modules.
// ----------------------------------------------------------------------------
package rgbgm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIDE   = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 13;
  localparam int FW_W       = 9;
  localparam int FH_W       = 13;
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

  localparam int TB_DLY  = 5;
  localparam int OUT_DLY = 10;

  localparam logic [15:0] W_CORNER = 16'd4923;
  localparam logic [15:0] W_EDGE   = 16'd8116;
  localparam logic [15:0] W_CENTER = 16'd13381;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t bot;
    pix_t mid;
    pix_t top;
  } col_t;

  typedef struct packed {
    col_t l_col;
    col_t c_col;
    col_t r_col;
  } win_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] addr;
    logic             top_same;
    logic             bot_same;
    logic             emit;
    logic             left_edge;
    logic             right_edge;
  } tick_t;

  typedef struct packed {
    logic emit;
    logic last;
  } out_tag_t;

endpackage

// ===== rtl/rgbgm_window.sv =====
// ----------------------------------------------------------------------------
// rgbgm_window
// Two-row line memory with read-modify-write per column and a 3x3 window
// built from shifted columns, with edge replication.
// ----------------------------------------------------------------------------
module rgbgm_window import rgbgm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  tick_t tick,
  input  pix_t  pixel,
  output win_t  window
);

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;
  tick_t              s1_r;
  pix_t               pix_r;
  col_t               c1_r;
  col_t               c2_r;
  win_t               win_r;
  col_t               col_new;
  win_t               win_nxt;

  always_comb begin
    col_new.mid = rd_data_r[2*PIX_W-1:PIX_W];
    col_new.top = s1_r.top_same ? rd_data_r[2*PIX_W-1:PIX_W] : rd_data_r[PIX_W-1:0];
    col_new.bot = s1_r.bot_same ? rd_data_r[2*PIX_W-1:PIX_W] : pix_r;
  end

  always_comb begin
    if (s1_r.left_edge) begin
      win_nxt = '{l_col: c2_r, c_col: c2_r, r_col: col_new};
    end else if (s1_r.right_edge) begin
      win_nxt = '{l_col: c1_r, c_col: c2_r, r_col: c2_r};
    end else begin
      win_nxt = '{l_col: c1_r, c_col: c2_r, r_col: col_new};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid) begin
      rd_data_r <= line_mem[tick.addr];
    end
    pix_r <= pixel;
    if (s1_r.valid) begin
      line_mem[s1_r.addr] <= {pix_r, col_new.mid};
      c1_r <= c2_r;
      c2_r <= col_new;
      if (s1_r.emit) begin
        win_r <= win_nxt;
      end
    end
  end

  assign window = win_r;

endmodule

// ===== rtl/rgbgm_blur.sv =====
// ----------------------------------------------------------------------------
// rgbgm_blur
// Three-stage weighted sum of a 3x3 window per channel, Q0.16 weights,
// truncated and capped at 255.
// ----------------------------------------------------------------------------
module rgbgm_blur import rgbgm_pkg::*; (
  input  logic clk,
  input  win_t window,
  output pix_t blurred
);

  logic [CH_W+1:0] cs_r [3];
  logic [CH_W+1:0] es_r [3];
  logic [CH_W-1:0] ce_r [3];
  logic [23:0]     pc_r [3];
  logic [23:0]     pe_r [3];
  logic [23:0]     pm_r [3];
  pix_t            pix_r;
  pix_t            pix_nxt;

  function automatic logic [CH_W-1:0] chan(input pix_t p, input int ch);
    chan = p[ch*CH_W +: CH_W];
  endfunction

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      cs_r[ch] <= 10'(chan(window.l_col.top, ch)) + 10'(chan(window.l_col.bot, ch))
                + 10'(chan(window.r_col.top, ch)) + 10'(chan(window.r_col.bot, ch));
      es_r[ch] <= 10'(chan(window.c_col.top, ch)) + 10'(chan(window.c_col.bot, ch))
                + 10'(chan(window.l_col.mid, ch)) + 10'(chan(window.r_col.mid, ch));
      ce_r[ch] <= chan(window.c_col.mid, ch);
      pc_r[ch] <= 24'(cs_r[ch]) * 24'(W_CORNER);
      pe_r[ch] <= 24'(es_r[ch]) * 24'(W_EDGE);
      pm_r[ch] <= 24'(ce_r[ch]) * 24'(W_CENTER);
    end
    pix_r <= pix_nxt;
  end

  always_comb begin
    logic [24:0] acc;
    pix_nxt = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 25'(pc_r[ch]) + 25'(pe_r[ch]) + 25'(pm_r[ch]);
      pix_nxt[ch*CH_W +: CH_W] = (acc[24:16] > 9'd255) ? 8'd255 : acc[23:16];
    end
  end

  assign blurred = pix_r;

endmodule

// ===== rtl/rgbgm_median.sv =====
// ----------------------------------------------------------------------------
// rgbgm_median
// Three-stage median of a 3x3 window per channel: sort columns, reduce the
// lows, middles and highs, then take the middle of three.
// ----------------------------------------------------------------------------
module rgbgm_median import rgbgm_pkg::*; (
  input  logic clk,
  input  win_t window,
  output pix_t median
);

  logic [CH_W-1:0] lo_r [3][3];
  logic [CH_W-1:0] md_r [3][3];
  logic [CH_W-1:0] hi_r [3][3];
  logic [CH_W-1:0] a_r  [3];
  logic [CH_W-1:0] b_r  [3];
  logic [CH_W-1:0] c_r  [3];
  pix_t            med_r;
  col_t            cols [3];

  function automatic logic [CH_W-1:0] max2(input logic [CH_W-1:0] x, y);
    max2 = (x > y) ? x : y;
  endfunction

  function automatic logic [CH_W-1:0] min2(input logic [CH_W-1:0] x, y);
    min2 = (x < y) ? x : y;
  endfunction

  function automatic logic [CH_W-1:0] med3(input logic [CH_W-1:0] x, y, z);
    med3 = max2(min2(x, y), min2(max2(x, y), z));
  endfunction

  assign cols[0] = window.l_col;
  assign cols[1] = window.c_col;
  assign cols[2] = window.r_col;

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        lo_r[ch][k] <= min2(min2(cols[k].top[ch*CH_W +: CH_W], cols[k].mid[ch*CH_W +: CH_W]),
                            cols[k].bot[ch*CH_W +: CH_W]);
        md_r[ch][k] <= med3(cols[k].top[ch*CH_W +: CH_W], cols[k].mid[ch*CH_W +: CH_W],
                            cols[k].bot[ch*CH_W +: CH_W]);
        hi_r[ch][k] <= max2(max2(cols[k].top[ch*CH_W +: CH_W], cols[k].mid[ch*CH_W +: CH_W]),
                            cols[k].bot[ch*CH_W +: CH_W]);
      end
      a_r[ch] <= max2(max2(lo_r[ch][0], lo_r[ch][1]), lo_r[ch][2]);
      b_r[ch] <= med3(md_r[ch][0], md_r[ch][1], md_r[ch][2]);
      c_r[ch] <= min2(min2(hi_r[ch][0], hi_r[ch][1]), hi_r[ch][2]);
      med_r[ch*CH_W +: CH_W] <= med3(a_r[ch], b_r[ch], c_r[ch]);
    end
  end

  assign median = med_r;

endmodule

// ===== rtl/rgbgm_fifo.sv =====
// ----------------------------------------------------------------------------
// rgbgm_fifo
// Result queue in front of the output stream; space is reserved upstream.
// ----------------------------------------------------------------------------
module rgbgm_fifo import rgbgm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pix_t       push_pix,
  input  logic       push_last,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [23:0] out_tdata,
  output logic       out_tlast
);

  logic [PIX_W:0]      store_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r;
  logic [FIFO_AW-1:0]  rd_ptr_r;
  logic [CREDIT_W-1:0] count_r;
  logic                pop;

  assign out_tvalid = (count_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = store_r[rd_ptr_r][PIX_W-1:0];
  assign out_tlast  = store_r[rd_ptr_r][PIX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + CREDIT_W'(push) - CREDIT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= {push_last, push_pix};
    end
  end

endmodule

// ===== rtl/rgb_gaussian_then_median_filter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_gaussian_then_median_filter_unit
// 3x3 Gaussian blur followed by a 3x3 median on RGB pixels in raster order.
// ----------------------------------------------------------------------------
// One item is accepted per clock while in_tready is high. Each item either
// carries a pixel or, once the frame's pixels are all in, drains one pending
// result. A result passes through two read-modify-write stages at each of the
// two line memories, the three blur stages, the three median stages and the
// result queue write. A 16-entry result queue decouples the output;
// in_tready drops while 16 results are reserved and not yet taken. A frame of
// W x H pixels needs W*H pixel items followed by 2*(W+1) drain items;
// frame_end (tlast) marks its last result. A write to the frame width or
// height register restarts the frame.
`include "rgb_gaussian_then_median_filter_unit_macros.svh"

module rgb_gaussian_then_median_filter_unit import rgbgm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // red_in, green_in, blue_in
  input  logic                  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // red_out, green_out, blue_out
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FW_W-1:0]     width_r;
  logic [FH_W-1:0]     height_r;
  logic [FW_W-1:0]     w_eff;
  logic [FW_W-1:0]     wm1;
  logic [FH_W-1:0]     h_eff;
  logic [ROW_W-1:0]    a_row_r, bo_row_r, b_row_r, o_row_r;
  logic [COL_W-1:0]    a_col_r, bo_col_r, b_col_r, o_col_r;
  logic [CREDIT_W-1:0] credit_r;
  tick_t               tb_dly_r [TB_DLY];
  out_tag_t            od_dly_r [OUT_DLY];

  logic  in_acc, is_drain, in_done, blur_done, out_done;
  logic  a_past, b_past, tick_a, emit_a, tick_b, emit_b, last_b;
  logic  cfg_acc, out_acc;
  tick_t tick_a_s, tick_b_s;
  pix_t  blurred, median;
  win_t  win_a, win_b;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_acc   = out_tvalid && out_tready;
  assign in_tready = (credit_r < CREDIT_W'(FIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign is_drain  = (in_tuser == ACT_DRAIN);

  always_comb begin
    if (width_r < FW_W'(MIN_SIDE)) begin
      w_eff = FW_W'(MIN_SIDE);
    end else if (width_r > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < FH_W'(MIN_SIDE)) begin
      h_eff = FH_W'(MIN_SIDE);
    end else if (height_r > FH_W'(MAX_HEIGHT)) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign wm1 = w_eff - FW_W'(1);

  assign in_done   = (a_row_r >= h_eff);
  assign blur_done = (bo_row_r >= h_eff);
  assign out_done  = (o_row_r >= h_eff);
  assign a_past    = (a_row_r >= ROW_W'(2)) || (a_row_r == ROW_W'(1) && a_col_r != '0);
  assign b_past    = (b_row_r >= ROW_W'(2)) || (b_row_r == ROW_W'(1) && b_col_r != '0);
  assign tick_a    = in_acc && (is_drain ? (in_done && !blur_done) : !in_done);
  assign emit_a    = tick_a && a_past && !blur_done;
  assign tick_b    = emit_a || (in_acc && is_drain && in_done && blur_done);
  assign emit_b    = tick_b && b_past && !out_done;
  assign last_b    = emit_b && (o_row_r == h_eff - FH_W'(1)) && (o_col_r == wm1[COL_W-1:0]);

  always_comb begin
    tick_a_s.valid      = tick_a;
    tick_a_s.addr       = a_col_r;
    tick_a_s.top_same   = (a_row_r == ROW_W'(1));
    tick_a_s.bot_same   = in_done;
    tick_a_s.emit       = emit_a;
    tick_a_s.left_edge  = (bo_col_r == '0);
    tick_a_s.right_edge = (bo_col_r == wm1[COL_W-1:0]);
    tick_b_s.valid      = tick_b;
    tick_b_s.addr       = b_col_r;
    tick_b_s.top_same   = (b_row_r == ROW_W'(1));
    tick_b_s.bot_same   = (b_row_r >= h_eff);
    tick_b_s.emit       = emit_b;
    tick_b_s.left_edge  = (o_col_r == '0);
    tick_b_s.right_edge = (o_col_r == wm1[COL_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FW_W'(256);
      height_r <= FH_W'(256);
      a_row_r  <= '0;
      a_col_r  <= '0;
      bo_row_r <= '0;
      bo_col_r <= '0;
      b_row_r  <= '0;
      b_col_r  <= '0;
      o_row_r  <= '0;
      o_col_r  <= '0;
      credit_r <= '0;
      for (int i = 0; i < TB_DLY; i++) begin
        tb_dly_r[i] <= '0;
      end
      for (int i = 0; i < OUT_DLY; i++) begin
        od_dly_r[i] <= '0;
      end
    end else begin
      credit_r <= credit_r + CREDIT_W'(emit_b) - CREDIT_W'(out_acc);
      tb_dly_r[0] <= tick_b_s;
      for (int i = 1; i < TB_DLY; i++) begin
        tb_dly_r[i] <= tb_dly_r[i-1];
      end
      od_dly_r[0] <= '{emit: emit_b, last: last_b};
      for (int i = 1; i < OUT_DLY; i++) begin
        od_dly_r[i] <= od_dly_r[i-1];
      end
      if (cfg_acc && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_r <= cfg_data[FW_W-1:0];
        end else begin
          height_r <= cfg_data[FH_W-1:0];
        end
        a_row_r  <= '0;
        a_col_r  <= '0;
        bo_row_r <= '0;
        bo_col_r <= '0;
        b_row_r  <= '0;
        b_col_r  <= '0;
        o_row_r  <= '0;
        o_col_r  <= '0;
      end else if (last_b) begin
        a_row_r  <= '0;
        a_col_r  <= '0;
        bo_row_r <= '0;
        bo_col_r <= '0;
        b_row_r  <= '0;
        b_col_r  <= '0;
        o_row_r  <= '0;
        o_col_r  <= '0;
      end else begin
        if (tick_a) begin
          if (a_col_r == wm1[COL_W-1:0]) begin
            a_col_r <= '0;
            a_row_r <= a_row_r + ROW_W'(1);
          end else begin
            a_col_r <= a_col_r + COL_W'(1);
          end
        end
        if (emit_a) begin
          if (bo_col_r == wm1[COL_W-1:0]) begin
            bo_col_r <= '0;
            bo_row_r <= bo_row_r + ROW_W'(1);
          end else begin
            bo_col_r <= bo_col_r + COL_W'(1);
          end
        end
        if (tick_b) begin
          if (b_col_r == wm1[COL_W-1:0]) begin
            b_col_r <= '0;
            b_row_r <= b_row_r + ROW_W'(1);
          end else begin
            b_col_r <= b_col_r + COL_W'(1);
          end
        end
        if (emit_b) begin
          if (o_col_r == wm1[COL_W-1:0]) begin
            o_col_r <= '0;
            o_row_r <= o_row_r + ROW_W'(1);
          end else begin
            o_col_r <= o_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  rgbgm_window u_win_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (tick_a_s),
    .pixel  (in_tdata),
    .window (win_a)
  );

  rgbgm_blur u_blur (
    .clk     (clk),
    .window  (win_a),
    .blurred (blurred)
  );

  rgbgm_window u_win_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (tb_dly_r[TB_DLY-1]),
    .pixel  (blurred),
    .window (win_b)
  );

  rgbgm_median u_median (
    .clk    (clk),
    .window (win_b),
    .median (median)
  );

  rgbgm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (od_dly_r[OUT_DLY-1].emit),
    .push_pix   (median),
    .push_last  (od_dly_r[OUT_DLY-1].last),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `RGBGM_ASSERT_IMP(a_credit_bound, 1'b1, credit_r <= CREDIT_W'(FIFO_DEPTH), "credit overflow")
  `RGBGM_ASSERT_IMP(a_drain_yields, in_acc && is_drain && in_done, emit_b, "drain without result")
  `RGBGM_ASSERT_IMP(a_blur_feeds_rank, emit_a, tick_b, "blurred pixel lost")
  `RGBGM_ASSERT_NXT(a_frame_restart, last_b && !cfg_acc,
                    a_row_r == '0 && bo_row_r == '0 && o_row_r == '0, "no restart after frame")

endmodule

// ===== sim/rgbgm_scoreboard.sv =====
// ----------------------------------------------------------------------------
// rgbgm_scoreboard
// Watches the pixel, result and register channels of the filter unit, keeps
// its own Gaussian-then-median pipeline state, and compares each result item
// in order against the predicted pixel and frame-end flag.
// ----------------------------------------------------------------------------
module rgbgm_scoreboard import rgbgm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [23:0]           in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [23:0]           out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen
);

  localparam int RING = 5;

  typedef struct {
    pix_t rgb;
    logic last;
  } filtered_px_t;

  pix_t         raw_rows  [RING][MAX_WIDTH];
  pix_t         blur_rows [RING][MAX_WIDTH];
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  int           in_row, in_col, bl_row, bl_col, px_row, px_col;
  filtered_px_t filtered_q[$];

  assign pending = filtered_q.size();

  function automatic int weight_of(int dist2);
    if (dist2 == 0) return int'(W_CENTER);
    if (dist2 == 1) return int'(W_EDGE);
    return int'(W_CORNER);
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pix_t blurred_at(int r, int c, int w, int h);
    pix_t res;
    int   acc [3];
    pix_t p;
    acc = '{0, 0, 0};
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        p = raw_rows[clamp(r + dy, 0, h - 1) % RING][clamp(c + dx, 0, w - 1)];
        for (int ch = 0; ch < 3; ch++)
          acc[ch] += weight_of(dy * dy + dx * dx) * int'(p[ch*8 +: 8]);
      end
    end
    for (int ch = 0; ch < 3; ch++)
      res[ch*8 +: 8] = ((acc[ch] >> 16) > 255) ? 8'd255 : 8'((acc[ch] >> 16));
    return res;
  endfunction

  function automatic pix_t median_at(int r, int c, int w, int h);
    pix_t res;
    logic [7:0] vals [9];
    logic [7:0] tmp;
    pix_t p;
    for (int ch = 0; ch < 3; ch++) begin
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          p = blur_rows[clamp(r + dy, 0, h - 1) % RING][clamp(c + dx, 0, w - 1)];
          vals[(dy + 1) * 3 + dx + 1] = p[ch*8 +: 8];
        end
      for (int i = 1; i < 9; i++)
        for (int j = i; j > 0 && vals[j-1] > vals[j]; j--) begin
          tmp       = vals[j];
          vals[j]   = vals[j-1];
          vals[j-1] = tmp;
        end
      res[ch*8 +: 8] = vals[4];
    end
    return res;
  endfunction

  task automatic step_pos(ref int r, ref int c, input int w);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
  endtask

  task automatic restart_frame();
    in_row = 0; in_col = 0;
    bl_row = 0; bl_col = 0;
    px_row = 0; px_col = 0;
    filtered_q.delete();
  endtask

  function automatic bit blur_due(int w, int h);
    if (bl_row >= h) return 0;
    if (in_row >= h) return 1;
    return in_row * w + in_col >= bl_row * w + bl_col + w + 2;
  endfunction

  function automatic bit median_due(int w, int h);
    if (px_row >= h) return 0;
    if (bl_row >= h) return 1;
    return bl_row * w + bl_col >= px_row * w + px_col + w + 2;
  endfunction

  task automatic blur_next(int w, int h);
    blur_rows[bl_row % RING][bl_col] = blurred_at(bl_row, bl_col, w, h);
    step_pos(bl_row, bl_col, w);
  endtask

  task automatic median_next(int w, int h);
    filtered_px_t e;
    e.rgb  = median_at(px_row, px_col, w, h);
    e.last = (px_row == h - 1 && px_col == w - 1);
    filtered_q.push_back(e);
    step_pos(px_row, px_col, w);
    if (px_row >= h) begin
      in_row = 0; in_col = 0;
      bl_row = 0; bl_col = 0;
      px_row = 0; px_col = 0;
    end
  endtask

  task automatic take_item(logic act, pix_t px);
    int w, h;
    w = clamp(int'(width_reg), MIN_SIDE, MAX_WIDTH);
    h = clamp(int'(height_reg), MIN_SIDE, MAX_HEIGHT);
    if (act == ACT_PIXEL) begin
      if (in_row >= h) return;
      raw_rows[in_row % RING][in_col] = px;
      step_pos(in_row, in_col, w);
      if (blur_due(w, h)) blur_next(w, h);
      if (median_due(w, h)) median_next(w, h);
    end else begin
      if (in_row < h) return;
      while (!median_due(w, h) && blur_due(w, h)) blur_next(w, h);
      if (median_due(w, h)) median_next(w, h);
    end
  endtask

  always @(posedge clk) begin
    filtered_px_t e;
    if (!rst_n) begin
      width_reg  = 9'd256;
      height_reg = 13'd256;
      restart_frame();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_data[FW_W-1:0];
          restart_frame();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_data[FH_W-1:0];
          restart_frame();
        end
      end
      if (in_tvalid && in_tready) take_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result item rgb=%h last=%b", $time, out_tdata, out_tlast);
        end else begin
          e = filtered_q.pop_front();
          if (out_tdata !== e.rgb) begin
            fail_count++;
            $display("%0t: rgb mismatch expected %h actual %h", $time, e.rgb, out_tdata);
          end
          if (out_tlast !== e.last) begin
            fail_count++;
            $display("%0t: frame_end mismatch expected %b actual %b", $time, e.last,
                     out_tlast);
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_rgb_gaussian_then_median_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_gaussian_then_median_filter_unit
// Feeds frames of many sizes, including clamped register values, edge-valued
// and random pixels, ignored and dropped items and back-pressure, and lets
// the scoreboard check every filtered pixel and frame-end flag.
// ----------------------------------------------------------------------------
module tb_rgb_gaussian_then_median_filter_unit import rgbgm_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 30;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending, results_seen;
  int send_idle, recv_idle, hold_cycles;
  int items_sent, frames_run;

  rgb_gaussian_then_median_filter_unit uut (.*);

  rgbgm_scoreboard scoreboard (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .results_seen
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 0;
        repeat (hold_cycles - 1) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic put_item(logic act, logic [23:0] px);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= act;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_pixel(bit edgy);
    if (!edgy) return 24'($urandom);
    case ($urandom_range(0, 3))
      0: return 24'h000000;
      1: return 24'hffffff;
      2: return $urandom_range(0, 1) ? 24'h55aa55 : 24'haa55aa;
      default: return {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                       {8{$urandom_range(0, 1) == 1}}};
    endcase
  endfunction

  task automatic run_frame(int wv, int hv, bit edgy, int noise_pct);
    int w, h;
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(wv));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(hv));
    w = (wv < MIN_SIDE) ? MIN_SIDE : (wv > MAX_WIDTH) ? MAX_WIDTH : wv;
    h = (hv < MIN_SIDE) ? MIN_SIDE : (hv > MAX_HEIGHT) ? MAX_HEIGHT : hv;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < noise_pct) put_item(ACT_DRAIN, 24'($urandom));
      put_item(ACT_PIXEL, pick_pixel(edgy));
    end
    for (int i = 0; i < 2 * (w + 1); i++) begin
      if ($urandom_range(0, 99) < noise_pct) put_item(ACT_PIXEL, 24'($urandom));
      put_item(ACT_DRAIN, 24'($urandom));
    end
    settle();
    frames_run++;
  endtask

  task automatic random_frames(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) run_frame($urandom_range(0, 2), $urandom_range(0, 4), 0, 10);
      else run_frame($urandom_range(3, 14), $urandom_range(3, 8), $urandom_range(0, 3) == 0, 10);
    end
  endtask

  initial begin
    rst_n       = 0;
    in_tvalid   = 0;
    in_tdata    = 0;
    in_tuser    = ACT_PIXEL;
    cfg_valid   = 0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = 0;
    hold_cycles = 0;
    items_sent  = 0;
    frames_run  = 0;
    send_idle   = 23;
    recv_idle   = 75;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    run_frame(3, 3, 1, 0);
    write_reg(REG_SPARE_A, 13'h1fff);
    write_reg(REG_SPARE_B, 13'h0000);
    run_frame(0, 0, 1, 30);
    run_frame(2, 2, 1, 0);
    run_frame(5, 4, 1, 20);
    random_frames(2);

    send_idle = 75;
    recv_idle = 23;
    hold_cycles = 400;
    run_frame(20, 3, 0, 5);
    random_frames(2);
    hold_cycles = 300;
    run_frame(9, 6, 0, 0);

    send_idle = 0;
    recv_idle = 0;
    run_frame(12, 1, 1, 2);
    random_frames(2);

    settle();
    $display("Ran %0d frames with %0d input items; %0d filtered pixels were checked.",
             frames_run, items_sent, results_seen);
    $display("Covered clamped sizes, ignored drains, dropped pixels and back-pressure.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rgbgm_pkg.sv
rtl/rgbgm_window.sv
rtl/rgbgm_blur.sv
rtl/rgbgm_median.sv
rtl/rgbgm_fifo.sv
rtl/rgb_gaussian_then_median_filter_unit.sv
sim/rgbgm_scoreboard.sv
sim/tb_rgb_gaussian_then_median_filter_unit.sv
